// File: hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file fpt_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define FPT_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Overlapping implication built on the one above.
`define FPT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  `FPT_ASSERT(lbl, clk, rst, (ante) |-> (cons), msg)

`endif

// File: hw/rtl/fpt_pkg.sv
package fpt_pkg;

  localparam int FINGERS   = 5;
  localparam int PRESS_W   = 10;
  localparam int IDX_W     = 3;
  localparam int LEN_W     = 5;
  localparam int WORD_W    = 32;
  localparam int RUN_W     = 4;
  localparam int SYM_SLOTS = WORD_W / 2;

  localparam logic [RUN_W-1:0] END_COUNT_RST = 4'd3;

  typedef logic [1:0] sym_t;

  localparam sym_t SYM_RISE   = 2'd0;
  localparam sym_t SYM_FALL   = 2'd1;
  localparam sym_t SYM_STEADY = 2'd2;
  localparam sym_t SYM_MASK   = 2'd3;

endpackage

// File: hw/rtl/fpt_if.sv
interface fpt_in_if;
  logic                       valid;
  logic                       ready;
  logic [fpt_pkg::PRESS_W-1:0] press_f0;
  logic [fpt_pkg::PRESS_W-1:0] press_f1;
  logic [fpt_pkg::PRESS_W-1:0] press_f2;
  logic [fpt_pkg::PRESS_W-1:0] press_f3;
  logic [fpt_pkg::PRESS_W-1:0] press_f4;

  modport source (output valid, press_f0, press_f1, press_f2, press_f3, press_f4,
                  input ready);
  modport sink   (input valid, press_f0, press_f1, press_f2, press_f3, press_f4,
                  output ready);
endinterface

interface fpt_out_if;
  logic                       valid;
  logic                       ready;
  logic [fpt_pkg::IDX_W-1:0]  finger_index;
  logic [fpt_pkg::LEN_W-1:0]  symbol_count;
  logic [fpt_pkg::WORD_W-1:0] symbol_word;
  logic                       overflowed;
  logic                       last_finger;

  modport source (output valid, finger_index, symbol_count, symbol_word, overflowed,
                  last_finger, input ready);
  modport sink   (input valid, finger_index, symbol_count, symbol_word, overflowed,
                  last_finger, output ready);
endinterface

interface fpt_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [fpt_pkg::RUN_W-1:0] end_equal_count;

  modport source (output valid, end_equal_count, input ready);
  modport sink   (input valid, end_equal_count, output ready);
endinterface

// File: hw/rtl/finger_pressure_trend_symbolizer_core.sv
// channel  dir  beat
// in_ch    in   five finger pressures
// out_ch   out  one finger's symbol sequence, five beats per gesture end
// cfg      in   end_equal_count
//
// An input register, refilled as its packet advances, feeds per-finger compare
// and append logic that updates state and, on a gesture end, loads a five-entry
// result buffer, drained one beat per cycle while out_ch.ready is high; a packet
// ending a gesture waits in the input register only while a prior burst drains.
// Synchronous reset clears control and gesture state, sets end_equal_count to 3.
module finger_pressure_trend_symbolizer_core #(
  parameter int MAX_SYMBOLS = 16,
  parameter int PRESS_BITS  = 10
) (
  input  logic      clk,
  input  logic      rst,
  fpt_in_if.sink    in_ch,
  fpt_out_if.source out_ch,
  fpt_cfg_if.sink   cfg
);
  import fpt_pkg::*;

  localparam int CAP = (MAX_SYMBOLS > SYM_SLOTS) ? SYM_SLOTS : MAX_SYMBOLS;
  localparam logic [LEN_W-1:0] CAP_L  = LEN_W'(CAP);
  localparam logic [IDX_W-1:0] LAST_F = IDX_W'(FINGERS - 1);

  // input register
  logic                  s1_valid;
  logic [PRESS_BITS-1:0] s1_press [FINGERS];

  // gesture state
  logic [RUN_W-1:0]      end_count;
  logic                  primed;
  logic [PRESS_BITS-1:0] prev [FINGERS];
  logic [RUN_W-1:0]      run [FINGERS];
  logic [WORD_W-1:0]     store [FINGERS];
  logic [LEN_W-1:0]      len [FINGERS];
  logic                  ovf [FINGERS];

  // result buffer
  logic                  b_busy;
  logic [IDX_W-1:0]      b_idx;
  logic [LEN_W-1:0]      b_len [FINGERS];
  logic [WORD_W-1:0]     b_word [FINGERS];
  logic                  b_ovf [FINGERS];

  // next-state terms
  logic [RUN_W-1:0]      run_next [FINGERS];
  logic [WORD_W-1:0]     store_next [FINGERS];
  logic [LEN_W-1:0]      len_next [FINGERS];
  logic                  ovf_next [FINGERS];
  logic [LEN_W-1:0]      tlen [FINGERS];
  logic [WORD_W-1:0]     tword [FINGERS];
  sym_t                  sym [FINGERS];
  sym_t                  last_sym [FINGERS];
  logic                  push [FINGERS];
  logic [3:0]            last_pos [FINGERS];
  logic                  all_end;

  logic s1_end, s1_adv, out_take, burst_done, in_take;

  always_comb begin
    all_end = 1'b1;
    for (int f = 0; f < FINGERS; f++) begin
      run_next[f]   = run[f];
      store_next[f] = store[f];
      len_next[f]   = len[f];
      ovf_next[f]   = ovf[f];
      sym[f]        = SYM_STEADY;
      push[f]       = 1'b0;
      if (s1_press[f] < prev[f]) begin
        run_next[f] = '0;
        sym[f]      = SYM_FALL;
        push[f]     = 1'b1;
      end else if (s1_press[f] > prev[f]) begin
        run_next[f] = '0;
        sym[f]      = SYM_RISE;
        push[f]     = 1'b1;
      end else begin
        if (run[f] < end_count) begin
          run_next[f] = run[f] + 1'b1;
        end
        push[f] = (len[f] != '0);
      end
      last_pos[f] = len[f][3:0] - 1'b1;
      last_sym[f] = sym_t'(store[f] >> {last_pos[f], 1'b0});
      if (push[f] && !((len[f] != '0) && (last_sym[f] == sym[f]))) begin
        if (len[f] >= CAP_L) begin
          ovf_next[f] = 1'b1;
        end else begin
          store_next[f] = store[f] | (WORD_W'(sym[f]) << {len[f][3:0], 1'b0});
          len_next[f]   = len[f] + 1'b1;
        end
      end
      if (run_next[f] < end_count) begin
        all_end = 1'b0;
      end
      // drop the trailing symbol of sequences longer than one
      tlen[f]  = len_next[f];
      tword[f] = store_next[f];
      if (len_next[f] > LEN_W'(1)) begin
        tlen[f]  = len_next[f] - 1'b1;
        tword[f] = store_next[f] & ~(WORD_W'(SYM_MASK) << {tlen[f][3:0], 1'b0});
      end
    end
  end

  assign out_take   = b_busy && out_ch.ready;
  assign burst_done = out_take && (b_idx == LAST_F);
  assign s1_end     = s1_valid && primed && all_end;
  assign s1_adv     = s1_valid && (!s1_end || !b_busy || burst_done);
  assign in_take    = in_ch.valid && in_ch.ready;

  assign in_ch.ready = !s1_valid || s1_adv;
  assign cfg.ready   = 1'b1;

  assign out_ch.valid        = b_busy;
  assign out_ch.finger_index = b_idx;
  assign out_ch.symbol_count = b_len[b_idx];
  assign out_ch.symbol_word  = b_word[b_idx];
  assign out_ch.overflowed   = b_ovf[b_idx];
  assign out_ch.last_finger  = (b_idx == LAST_F);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      end_count <= END_COUNT_RST;
      primed    <= 1'b0;
      b_busy    <= 1'b0;
      b_idx     <= '0;
      for (int f = 0; f < FINGERS; f++) begin
        prev[f]  <= '0;
        run[f]   <= '0;
        store[f] <= '0;
        len[f]   <= '0;
        ovf[f]   <= 1'b0;
      end
    end else begin
      if (cfg.valid && cfg.ready) begin
        end_count <= cfg.end_equal_count;
      end
      if (in_take) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv && s1_end) begin
        b_busy <= 1'b1;
        b_idx  <= '0;
      end else if (out_take) begin
        if (b_idx == LAST_F) begin
          b_busy <= 1'b0;
          b_idx  <= '0;
        end else begin
          b_idx <= b_idx + 1'b1;
        end
      end
      if (s1_adv) begin
        for (int f = 0; f < FINGERS; f++) begin
          prev[f] <= s1_press[f];
        end
        if (!primed) begin
          primed <= 1'b1;
        end else if (s1_end) begin
          primed <= 1'b0;
          for (int f = 0; f < FINGERS; f++) begin
            run[f]   <= '0;
            store[f] <= '0;
            len[f]   <= '0;
            ovf[f]   <= 1'b0;
          end
        end else begin
          for (int f = 0; f < FINGERS; f++) begin
            run[f]   <= run_next[f];
            store[f] <= store_next[f];
            len[f]   <= len_next[f];
            ovf[f]   <= ovf_next[f];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_press[0] <= PRESS_BITS'(in_ch.press_f0);
      s1_press[1] <= PRESS_BITS'(in_ch.press_f1);
      s1_press[2] <= PRESS_BITS'(in_ch.press_f2);
      s1_press[3] <= PRESS_BITS'(in_ch.press_f3);
      s1_press[4] <= PRESS_BITS'(in_ch.press_f4);
    end
    if (s1_adv && primed && s1_end) begin
      for (int f = 0; f < FINGERS; f++) begin
        b_len[f]  <= tlen[f];
        b_word[f] <= tword[f];
        b_ovf[f]  <= ovf_next[f];
      end
    end
  end

endmodule

// File: hw/rtl/fpt_checker.sv
`include "assert_macros.svh"

module fpt_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [fpt_pkg::IDX_W-1:0]      finger_index,
  input logic [fpt_pkg::LEN_W-1:0]      symbol_count,
  input logic [fpt_pkg::WORD_W-1:0]     symbol_word,
  input logic                           last_finger
);
  import fpt_pkg::*;

  `FPT_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(finger_index) && $stable(symbol_word), "stalled result beat changed")
  `FPT_ASSERT(a_burst_step, clk, rst, out_valid && out_ready && !last_finger |=> out_valid && (finger_index == $past(finger_index) + 3'd1), "burst skipped or stopped")
  `FPT_ASSERT(a_burst_wrap, clk, rst, out_valid && out_ready && last_finger |=> !out_valid || (finger_index == 3'd0), "burst did not restart at finger 0")
  `FPT_IMPLY(a_last_mark, clk, rst, out_valid, last_finger == (finger_index == 3'd4), "last mark not on finger 4")
  `FPT_IMPLY(a_word_len, clk, rst, out_valid, (symbol_count <= 5'd16) && (symbol_count != 5'd0 || symbol_word == 32'd0), "symbol word inconsistent with count")

endmodule

bind finger_pressure_trend_symbolizer_core fpt_checker u_fpt_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .finger_index (out_ch.finger_index),
  .symbol_count (out_ch.symbol_count),
  .symbol_word  (out_ch.symbol_word),
  .last_finger  (out_ch.last_finger)
);
